### hw/rtl/sha256bh_pkg.sv
package sha256bh_pkg;

  typedef enum logic [1:0] {
    BYTE_DATA,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_t;

  typedef struct packed {
    logic      shift_en;
    byte_sel_t byte_sel;
    logic [2:0] len_idx;
    logic      count_en;
    logic      load_work;
    logic      round_en;
    logic [5:0] round_idx;
    logic      fold;
    logic      hash_init;
    logic [2:0] out_idx;
  } dp_cmd_t;

  localparam logic [31:0] INIT_H [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

### hw/rtl/sha256bh_in_if.sv
interface sha256bh_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] data_byte;

  modport source (output valid, output func, output data_byte, input ready);
  modport sink (input valid, input func, input data_byte, output ready);
endinterface

### hw/rtl/sha256bh_out_if.sv
interface sha256bh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last;

  modport source (output valid, output digest_word, output word_index, output last,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last,
                output ready);
endinterface

### hw/rtl/sha256_byte_stream_hasher_core.sv
// SHA-256 hasher fed one message byte per request on the msg channel.
// A request with func low appends data_byte to the current message; a
// request with func high closes the message, pads it and returns the digest
// on the digest channel as eight requests, H0 first, last set on the eighth.
// The byte that completes a 64-byte block starts the compression: 64 rounds
// through the single round unit, then a fold of the result into the hash
// words. msg is not ready during the compression, so no new byte is taken
// until the block has been folded into the hash words.
// A finish request shifts in the marker and zero padding at one byte a cycle
// up to byte 56 (through an extra compression when the marker lands beyond
// byte 56), then the eight length bytes and a final compression, after which
// the digest words are offered.
// While the receiver holds ready low the current digest word stays on the
// port and no further request is taken until the eighth word has gone.
// After that the hash state is reinitialised for the next message.
// Reset loads the initial hash values and clears all counts; msg ready is
// already high while reset is still held.
module sha256_byte_stream_hasher_core (
  input logic            clk,
  input logic            rst,
  sha256bh_in_if.sink    msg,
  sha256bh_out_if.source digest
);
  import sha256bh_pkg::*;

  dp_cmd_t    cmd;
  logic       out_last;
  logic [2:0] out_idx;

  sha256bh_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (msg.valid),
    .in_func   (msg.func),
    .in_ready  (msg.ready),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .out_last  (out_last),
    .out_idx   (out_idx),
    .cmd       (cmd)
  );

  sha256bh_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .data_byte   (msg.data_byte),
    .cmd         (cmd),
    .digest_word (digest.digest_word)
  );

  assign digest.word_index = out_idx;
  assign digest.last       = out_last;

endmodule

### hw/rtl/sha256bh_ctrl.sv
module sha256bh_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_func,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_last,
  output logic [2:0]            out_idx,
  output sha256bh_pkg::dp_cmd_t cmd
);
  import sha256bh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COMP,
    S_FOLD,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_EMIT
  } state_t;

  typedef enum logic [1:0] {
    M_ABSORB,
    M_PAD,
    M_FINAL
  } mode_t;

  state_t     state;
  mode_t      mode;
  logic [5:0] fill;
  logic [5:0] round;
  logic [2:0] step;
  logic       in_accept;
  logic       out_accept;

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_EMIT);
  assign out_idx    = step;
  assign out_last   = (step == 3'd7);
  assign in_accept  = in_valid && in_ready;
  assign out_accept = out_valid && out_ready;

  always_comb begin
    cmd           = '0;
    cmd.byte_sel  = BYTE_ZERO;
    cmd.len_idx   = step;
    cmd.round_idx = round;
    cmd.out_idx   = step;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          cmd.shift_en  = 1'b1;
          cmd.byte_sel  = in_func ? BYTE_PAD : BYTE_DATA;
          cmd.count_en  = !in_func;
          cmd.load_work = (fill == 6'd63);
        end
      end
      S_COMP: cmd.round_en = 1'b1;
      S_FOLD: cmd.fold = 1'b1;
      S_PAD_ZERO: begin
        if (fill != 6'd56) begin
          cmd.shift_en  = 1'b1;
          cmd.load_work = (fill == 6'd63);
        end
      end
      S_PAD_LEN: begin
        cmd.shift_en  = 1'b1;
        cmd.byte_sel  = BYTE_LEN;
        cmd.load_work = (step == 3'd7);
      end
      S_EMIT: cmd.hash_init = out_accept && (step == 3'd7);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      mode  <= M_ABSORB;
      fill  <= '0;
      round <= '0;
      step  <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            fill <= fill + 6'd1;
            if (in_func) begin
              // A marker byte that completes the block forces an extra block.
              if (fill == 6'd63) begin
                mode  <= M_PAD;
                state <= S_COMP;
              end else begin
                state <= S_PAD_ZERO;
              end
            end else if (fill == 6'd63) begin
              mode  <= M_ABSORB;
              state <= S_COMP;
            end
          end
        end
        S_COMP: begin
          round <= round + 6'd1;
          if (round == 6'd63) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          case (mode)
            M_ABSORB: state <= S_IDLE;
            M_PAD:    state <= S_PAD_ZERO;
            M_FINAL: begin
              step  <= '0;
              state <= S_EMIT;
            end
            default:  state <= S_IDLE;
          endcase
        end
        S_PAD_ZERO: begin
          if (fill == 6'd56) begin
            step  <= '0;
            state <= S_PAD_LEN;
          end else begin
            fill <= fill + 6'd1;
            if (fill == 6'd63) begin
              mode  <= M_PAD;
              state <= S_COMP;
            end
          end
        end
        S_PAD_LEN: begin
          step <= step + 3'd1;
          if (step == 3'd7) begin
            mode  <= M_FINAL;
            state <= S_COMP;
          end
        end
        S_EMIT: begin
          if (out_accept) begin
            step <= step + 3'd1;
            if (step == 3'd7) begin
              fill  <= '0;
              mode  <= M_ABSORB;
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/sha256bh_datapath.sv
module sha256bh_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            data_byte,
  input  sha256bh_pkg::dp_cmd_t cmd,
  output logic [31:0]           digest_word
);
  import sha256bh_pkg::*;

  function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned s);
    logic [63:0] d;
    d = {x, x} >> s;
    return d[31:0];
  endfunction

  // The 64-byte block fills as a shift line, first byte at the top, and the
  // same storage then rolls as the 16-word message schedule.
  logic [511:0] blk;
  logic [31:0]  hash [8];
  logic [31:0]  work [8];
  logic [60:0]  total;

  logic [63:0]  len_bits;
  logic [7:0]   byte_in;
  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  s0, s1, ch, maj, t1, t2;

  assign len_bits = {total, 3'b000};
  assign w0  = blk[511:480];
  assign w1  = blk[479:448];
  assign w9  = blk[223:192];
  assign w14 = blk[63:32];

  always_comb begin
    case (cmd.byte_sel)
      BYTE_DATA: byte_in = data_byte;
      BYTE_PAD:  byte_in = 8'h80;
      BYTE_LEN:  byte_in = len_bits[{~cmd.len_idx, 3'b000} +: 8];
      default:   byte_in = 8'h00;
    endcase
  end

  always_comb begin
    w_new = (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10)) + w9
          + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w0;
    s1  = ror(work[4], 6) ^ ror(work[4], 11) ^ ror(work[4], 25);
    s0  = ror(work[0], 2) ^ ror(work[0], 13) ^ ror(work[0], 22);
    ch  = (work[4] & work[5]) ^ (~work[4] & work[6]);
    maj = (work[0] & work[1]) ^ (work[0] & work[2]) ^ (work[1] & work[2]);
    t1  = work[7] + s1 + ch + ROUND_K[cmd.round_idx] + w0;
    t2  = s0 + maj;
  end

  assign digest_word = hash[cmd.out_idx];

  always_ff @(posedge clk) begin
    if (cmd.shift_en) begin
      blk <= {blk[503:0], byte_in};
    end else if (cmd.round_en) begin
      blk <= {blk[479:0], w_new};
    end
    if (cmd.load_work) begin
      work <= hash;
    end else if (cmd.round_en) begin
      work <= '{t1 + t2, work[0], work[1], work[2], work[3] + t1,
                work[4], work[5], work[6]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.hash_init) begin
      hash  <= INIT_H;
      total <= '0;
    end else begin
      if (cmd.count_en) begin
        total <= total + 61'd1;
      end
      if (cmd.fold) begin
        for (int i = 0; i < 8; i++) begin
          hash[i] <= hash[i] + work[i];
        end
      end
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sha256bh_pkg::*;

  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  localparam int REQ_TARGET = 460;
  localparam int HOLD_AFTER_WORDS = 36;
  localparam int HOLD_CYCLES = 800;
  localparam int SETTLE_CYCLES = 300;

  localparam int BOUNDARY_LENS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef struct {
    logic       func;
    logic [7:0] data_byte;
    bit         drain_first;
  } msg_req_t;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sha256bh_in_if  msg ();
  sha256bh_out_if digest ();

  sha256_byte_stream_hasher_core dut (
    .clk    (clk),
    .rst    (rst),
    .msg    (msg),
    .digest (digest)
  );

  always #10 clk = ~clk;

  msg_req_t     send_queue [$];
  digest_word_t expected_words [$];

  // Running SHA-256 state of the message currently being absorbed.
  logic [31:0] hash_state [8];
  logic [7:0]  blk_buf [64];
  int          blk_fill;
  logic [60:0] msg_len;

  int  errors = 0;
  int  words_seen = 0;
  int  messages_hashed = 0;
  int  bytes_hashed = 0;
  int  cur_msg_bytes = 0;
  int  longest_msg = 0;
  int  reqs_queued = 0;
  int  send_gap = 0;
  int  send_quiet = 0;
  int  recv_stall = 0;
  int  recv_quiet = 0;
  logic hold_off = 1'b0;

  function automatic logic [31:0] rotr(logic [31:0] x, int s);
    return (x >> s) | (x << (32 - s));
  endfunction

  function automatic void restart_message();
    for (int i = 0; i < 8; i++) hash_state[i] = SHA_IV[i];
    for (int i = 0; i < 64; i++) blk_buf[i] = 8'h00;
    blk_fill = 0;
    msg_len = '0;
  endfunction

  function automatic void fold_block();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int r = 0; r < 16; r++)
      w[r] = {blk_buf[4*r], blk_buf[4*r+1], blk_buf[4*r+2], blk_buf[4*r+3]};
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int r = 0; r < 64; r++) begin
      if (r >= 16) begin
        s0 = rotr(w[(r-15)%16], 7) ^ rotr(w[(r-15)%16], 18) ^ (w[(r-15)%16] >> 3);
        s1 = rotr(w[(r-2)%16], 17) ^ rotr(w[(r-2)%16], 19) ^ (w[(r-2)%16] >> 10);
        w[r%16] = w[r%16] + s0 + w[(r-7)%16] + s1;
      end
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g)) +
           SHA_K[r] + w[r%16];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void absorb_byte(logic [7:0] b);
    blk_buf[blk_fill] = b;
    blk_fill++;
    msg_len++;
    if (blk_fill == 64) begin
      fold_block();
      blk_fill = 0;
    end
  endfunction

  function automatic void close_message();
    logic [63:0] bit_len;
    digest_word_t dw;
    bit_len = {msg_len, 3'b000};
    blk_buf[blk_fill] = 8'h80;
    blk_fill++;
    // With the marker beyond byte 56 the length no longer fits, so an extra block is needed.
    if (blk_fill > 56) begin
      for (int i = blk_fill; i < 64; i++) blk_buf[i] = 8'h00;
      fold_block();
      blk_fill = 0;
    end
    for (int i = blk_fill; i < 56; i++) blk_buf[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk_buf[63 - i] = bit_len[8*i +: 8];
    fold_block();
    for (int i = 0; i < 8; i++) begin
      dw.word = hash_state[i];
      dw.idx = 3'(i);
      dw.last = (i == 7);
      expected_words.push_back(dw);
    end
    restart_message();
  endfunction

  function automatic void queue_req(logic fn, logic [7:0] b, bit drain_first);
    msg_req_t rq;
    rq.func = fn;
    rq.data_byte = b;
    rq.drain_first = drain_first;
    send_queue.push_back(rq);
    reqs_queued++;
  endfunction

  function automatic void queue_message(int len, bit drain_first);
    for (int i = 0; i < len; i++) queue_req(FUNC_ABSORB, 8'($urandom), drain_first && i == 0);
    queue_req(FUNC_FINISH, 8'($urandom), drain_first && len == 0);
  endfunction

  // Mostly no gap, often a short one, now and then a long one; none in a quiet stretch.
  function automatic int pick_gap(int quiet);
    int pick;
    pick = $urandom_range(0, 99);
    if (quiet > 0 || pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin : drive_msg
    msg_req_t nxt;
    logic     offer;
    if (rst) begin
      msg.valid <= 1'b0;
      msg.func <= FUNC_ABSORB;
      msg.data_byte <= 8'h00;
    end else begin
      if (msg.valid && msg.ready) begin
        if (msg.func == FUNC_FINISH) begin
          close_message();
          messages_hashed++;
          if (cur_msg_bytes > longest_msg) longest_msg = cur_msg_bytes;
          cur_msg_bytes = 0;
        end else begin
          absorb_byte(msg.data_byte);
          bytes_hashed++;
          cur_msg_bytes++;
        end
      end
      if (send_quiet > 0) send_quiet--;
      else if ($urandom_range(0, 299) == 0) send_quiet = $urandom_range(60, 200);
      // A request still waiting for ready is held as it is.
      if (!(msg.valid && !msg.ready)) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (send_queue.size() != 0 &&
                     !(send_queue[0].drain_first && expected_words.size() != 0)) begin
          nxt = send_queue.pop_front();
          offer = 1'b1;
          send_gap = pick_gap(send_quiet);
        end
        msg.valid <= offer;
        if (offer) begin
          msg.func <= nxt.func;
          msg.data_byte <= nxt.data_byte;
        end
      end
    end
  end

  always @(posedge clk) begin : check_digest
    digest_word_t want;
    if (rst) begin
      digest.ready <= 1'b0;
    end else begin
      if (digest.valid && digest.ready) begin
        words_seen++;
        if (expected_words.size() == 0) begin
          errors++;
          $display("%0t: digest word with nothing expected: got word %h index %0d last %0b",
                   $time, digest.digest_word, digest.word_index, digest.last);
        end else begin
          want = expected_words.pop_front();
          if (digest.digest_word !== want.word || digest.word_index !== want.idx ||
              digest.last !== want.last) begin
            errors++;
            $display("%0t: digest mismatch: expected word %h index %0d last %0b, got word %h index %0d last %0b",
                     $time, want.word, want.idx, want.last,
                     digest.digest_word, digest.word_index, digest.last);
          end
        end
      end
      if (recv_quiet > 0) recv_quiet--;
      else if ($urandom_range(0, 299) == 0) recv_quiet = $urandom_range(60, 200);
      if (recv_stall > 0) recv_stall--;
      else if ($urandom_range(0, 3) == 0) recv_stall = pick_gap(recv_quiet);
      digest.ready <= !hold_off && recv_stall == 0;
    end
  end

  // Once, part way through a digest, the receiver holds off long enough for the
  // sender to back up against a stalled input.
  initial begin : long_hold
    while (words_seen < HOLD_AFTER_WORDS) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    #20ms;
    $display("%0t: run timed out with %0d requests queued and %0d digest words outstanding",
             $time, send_queue.size(), expected_words.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int len;
    int pick;
    msg.valid = 1'b0;
    msg.func = FUNC_ABSORB;
    msg.data_byte = 8'h00;
    digest.ready = 1'b0;
    restart_message();

    // Empty message with an all-ones byte that must be ignored, then a second
    // finish straight after, which hashes the empty message again.
    queue_req(FUNC_FINISH, 8'hff, 1'b0);
    queue_req(FUNC_FINISH, 8'h00, 1'b0);
    queue_req(FUNC_ABSORB, 8'h61, 1'b0);
    queue_req(FUNC_ABSORB, 8'h62, 1'b0);
    queue_req(FUNC_ABSORB, 8'h63, 1'b0);
    queue_req(FUNC_FINISH, 8'h5a, 1'b0);
    queue_req(FUNC_ABSORB, 8'hff, 1'b0);
    queue_req(FUNC_FINISH, 8'ha5, 1'b0);
    queue_req(FUNC_ABSORB, 8'h00, 1'b0);
    queue_req(FUNC_ABSORB, 8'hff, 1'b0);
    queue_req(FUNC_ABSORB, 8'h80, 1'b0);
    queue_req(FUNC_ABSORB, 8'h7f, 1'b0);
    queue_req(FUNC_ABSORB, 8'h01, 1'b0);
    queue_req(FUNC_ABSORB, 8'hfe, 1'b0);
    queue_req(FUNC_FINISH, 8'h00, 1'b0);

    // The first random message waits until every digest so far has come back.
    queue_message($urandom_range(0, 20), 1'b1);
    while (reqs_queued < REQ_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) len = $urandom_range(0, 20);
      else if (pick < 85) len = BOUNDARY_LENS[$urandom_range(0, 9)];
      else len = $urandom_range(21, 140);
      // The last message is cut short so that the request count lands on the target.
      if (len > REQ_TARGET - reqs_queued - 1) len = REQ_TARGET - reqs_queued - 1;
      queue_message(len, $urandom_range(0, 9) == 0);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (send_queue.size() != 0 || msg.valid) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("Hashed %0d messages from %0d data bytes, longest %0d bytes; %0d digest words checked.",
             messages_hashed, bytes_hashed, longest_msg, words_seen);
    $display("Errors found: %0d.", errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
